// ===== rtl/core/glr_pkg.sv =====
// glr_pkg: shared codes, defaults and types of the gradient line rasterizer
// depends on nothing; used by the interfaces, the ramp divider and the top level
`default_nettype none

package glr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS_DEF = 8;

  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned CFG_IDX_W = 3;

  // operation codes of an input item
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_RED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_GREEN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BLUE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_END_RED     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_END_GREEN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_END_BLUE    = 3'd5;

  // request to the ramp divider
  typedef struct packed {
    logic                start;
    logic [NUM_CH-1:0]   neg;
  } div_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/glr_in_if.sv =====
// glr_in_if: input channel of the rasterizer, valid/ready plus the line item
// depends on glr_pkg for the default coordinate width
`default_nettype none

interface glr_in_if #(
  parameter int unsigned COORD_BITS = glr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         op;
  logic signed [COORD_BITS-1:0] x0;
  logic signed [COORD_BITS-1:0] y0;
  logic signed [COORD_BITS-1:0] x1;
  logic signed [COORD_BITS-1:0] y1;

  modport source (output valid, op, x0, y0, x1, y1, input ready);
  modport sink   (input valid, op, x0, y0, x1, y1, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/glr_out_if.sv =====
// glr_out_if: result channel of the rasterizer, valid/ready plus one pixel item
// depends on glr_pkg for the default coordinate and colour widths
`default_nettype none

interface glr_out_if #(
  parameter int unsigned COORD_BITS = glr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = glr_pkg::COLOR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic        [COLOR_BITS-1:0] red;
  logic        [COLOR_BITS-1:0] green;
  logic        [COLOR_BITS-1:0] blue;
  logic                         last_pixel;

  modport source (output valid, pixel_x, pixel_y, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, red, green, blue, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/glr_ramp_div.sv =====
// glr_ramp_div: three-lane restoring divider, one quotient bit per cycle,
// giving the floored colour step quotient and remainder; depends on glr_pkg
`default_nettype none

module glr_ramp_div #(
  parameter int unsigned COLOR_BITS = glr_pkg::COLOR_BITS_DEF,
  parameter int unsigned SPAN_W     = glr_pkg::COORD_BITS_DEF + 1
) (
  input  wire                                                    clk_i,
  input  wire                                                    rst_ni,
  input  glr_pkg::div_req_t                                      req_i,
  input  wire  [glr_pkg::NUM_CH-1:0][COLOR_BITS-1:0]             mag_i,
  input  wire  [SPAN_W-1:0]                                      divisor_i,
  output logic                                                   busy_o,
  output logic [glr_pkg::NUM_CH-1:0][COLOR_BITS:0]               quot_o,
  output logic [glr_pkg::NUM_CH-1:0][SPAN_W-1:0]                 rem_o
);

  localparam int unsigned CNT_W = $clog2(COLOR_BITS + 1);

  logic [CNT_W-1:0]                               cnt_q, cnt_d;
  logic [SPAN_W-1:0]                              div_q, div_d;
  logic [glr_pkg::NUM_CH-1:0]                     neg_q, neg_d;
  logic [glr_pkg::NUM_CH-1:0][COLOR_BITS-1:0]     dvd_q, dvd_d;
  logic [glr_pkg::NUM_CH-1:0][SPAN_W-1:0]         rm_q, rm_d;

  assign busy_o = (cnt_q != '0);

  always_comb begin
    logic [SPAN_W:0] trial;
    logic            ge;
    trial = '0;
    ge    = 1'b0;
    cnt_d = cnt_q;
    div_d = div_q;
    neg_d = neg_q;
    dvd_d = dvd_q;
    rm_d  = rm_q;
    if (req_i.start) begin
      cnt_d = CNT_W'(COLOR_BITS);
      div_d = divisor_i;
      neg_d = req_i.neg;
      dvd_d = mag_i;
      rm_d  = '0;
    end else if (busy_o) begin
      cnt_d = cnt_q - 1'b1;
      for (int c = 0; c < glr_pkg::NUM_CH; c++) begin
        trial = {rm_q[c], dvd_q[c][COLOR_BITS-1]};
        ge    = (trial >= {1'b0, div_q});
        rm_d[c]  = ge ? SPAN_W'(trial - {1'b0, div_q}) : trial[SPAN_W-1:0];
        dvd_d[c] = {dvd_q[c][COLOR_BITS-2:0], ge};
      end
    end
  end

  // sign fix-up to a floored quotient with a non-negative remainder
  always_comb begin
    for (int c = 0; c < glr_pkg::NUM_CH; c++) begin
      if (neg_q[c] && (rm_q[c] != '0)) begin
        quot_o[c] = ~{1'b0, dvd_q[c]};
        rem_o[c]  = div_q - rm_q[c];
      end else if (neg_q[c]) begin
        quot_o[c] = -{1'b0, dvd_q[c]};
        rem_o[c]  = rm_q[c];
      end else begin
        quot_o[c] = {1'b0, dvd_q[c]};
        rem_o[c]  = rm_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      div_q <= '0;
      neg_q <= '0;
      dvd_q <= '0;
      rm_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      div_q <= div_d;
      neg_q <= neg_d;
      dvd_q <= dvd_d;
      rm_q  <= rm_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/gradient_line_rasterizer.sv =====
// gradient_line_rasterizer: midpoint line walker with a linear colour ramp
// depends on glr_pkg, glr_in_if, glr_out_if and glr_ramp_div
//
// Usage: a load item (op = 0) latches the endpoints x0,y0 and x1,y1 and the
// start and end colours from the configuration registers. Each step item
// (op = 1) then gives one pixel of the line, end point excluded, with
// last_pixel set on the final one. A step while no line is active, a load
// item and a zero-length line give no result. A load drops any line in work.
// Throughput: one step item per cycle. After a load of a line of non-zero
// length the input is held off while the ramp divider works out the colour
// step, one quotient bit per cycle in each lane. A pixel is registered into
// the output register when its step item is taken, or into the skid while
// the output register holds an item not yet taken. A two-entry output
// (register plus skid) keeps the input open while one result waits; when both
// entries are full the input stalls until the receiver takes an item.
// Reset: configuration returns to red at the start and blue at the end, no
// line is active and the output is empty. The user must write configuration
// through cfg_we_i, cfg_idx_i and cfg_data_i only while the block is idle;
// the block does not enforce it. Indexes beyond the register list are ignored.
`default_nettype none

module gradient_line_rasterizer #(
  parameter int unsigned COORD_BITS = glr_pkg::COORD_BITS_DEF,
  parameter int unsigned COLOR_BITS = glr_pkg::COLOR_BITS_DEF
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  glr_in_if.sink                         in_if,
  glr_out_if.source                      out_if,
  input  wire                            cfg_we_i,
  input  wire [glr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [COLOR_BITS-1:0]           cfg_data_i
);

  localparam int unsigned SPAN_W = COORD_BITS + 1;
  localparam int unsigned DEC_W  = COORD_BITS + 3;
  localparam int unsigned NCH    = glr_pkg::NUM_CH;

  // configuration
  logic [NCH-1:0][COLOR_BITS-1:0] start_q, end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= {{(2*COLOR_BITS){1'b0}}, {COLOR_BITS{1'b1}}};
      end_q   <= {{COLOR_BITS{1'b1}}, {(2*COLOR_BITS){1'b0}}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        glr_pkg::CFG_START_RED:   start_q[0] <= cfg_data_i;
        glr_pkg::CFG_START_GREEN: start_q[1] <= cfg_data_i;
        glr_pkg::CFG_START_BLUE:  start_q[2] <= cfg_data_i;
        glr_pkg::CFG_END_RED:     end_q[0]   <= cfg_data_i;
        glr_pkg::CFG_END_GREEN:   end_q[1]   <= cfg_data_i;
        glr_pkg::CFG_END_BLUE:    end_q[2]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // line state
  logic signed [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic        [SPAN_W-1:0]       major_q, major_d, minor_q, minor_d;
  logic signed [DEC_W-1:0]        dec_q, dec_d;
  logic        [SPAN_W-1:0]       steps_q, steps_d;
  logic        [2:0]              dir_q, dir_d;
  logic        [NCH-1:0][COLOR_BITS-1:0] val_q, val_d;
  logic        [NCH-1:0][SPAN_W-1:0]     err_q, err_d;
  logic                           active_q, active_d;

  // output register and skid
  logic                           out_valid_q, skid_valid_q;
  logic signed [COORD_BITS-1:0]   out_x_q, out_y_q, skid_x_q, skid_y_q;
  logic        [NCH-1:0][COLOR_BITS-1:0] out_c_q, skid_c_q;
  logic                           out_last_q, skid_last_q;

  logic                           div_busy;
  glr_pkg::div_req_t              div_req;
  logic [NCH-1:0][COLOR_BITS-1:0] div_mag;
  logic [NCH-1:0][COLOR_BITS:0]   div_quot;
  logic [NCH-1:0][SPAN_W-1:0]     div_rem;

  logic in_fire, load_fire, produce, out_fire, last_now;

  assign in_if.ready = !div_busy && !skid_valid_q;
  assign in_fire     = in_if.valid && in_if.ready;
  assign load_fire   = in_fire && (in_if.op == glr_pkg::OP_LOAD);
  assign produce     = in_fire && (in_if.op == glr_pkg::OP_STEP) && active_q;
  assign out_fire    = out_valid_q && out_if.ready;
  assign last_now    = (steps_q == SPAN_W'(1));

  // load set-up
  logic signed [COORD_BITS:0] dx_s, dy_s;
  logic        [SPAN_W-1:0]   dx_a, dy_a, ld_major, ld_minor;
  logic                       ld_steep;

  always_comb begin
    dx_s     = {in_if.x1[COORD_BITS-1], in_if.x1} - {in_if.x0[COORD_BITS-1], in_if.x0};
    dy_s     = {in_if.y1[COORD_BITS-1], in_if.y1} - {in_if.y0[COORD_BITS-1], in_if.y0};
    dx_a     = dx_s[COORD_BITS] ? SPAN_W'(-dx_s) : SPAN_W'(dx_s);
    dy_a     = dy_s[COORD_BITS] ? SPAN_W'(-dy_s) : SPAN_W'(dy_s);
    ld_steep = (dy_a > dx_a);
    ld_major = ld_steep ? dy_a : dx_a;
    ld_minor = ld_steep ? dx_a : dy_a;
  end

  always_comb begin
    div_req.start = load_fire && (ld_major != '0);
    for (int c = 0; c < NCH; c++) begin
      div_req.neg[c] = (end_q[c] < start_q[c]);
      div_mag[c]     = div_req.neg[c] ? (start_q[c] - end_q[c]) : (end_q[c] - start_q[c]);
    end
  end

  glr_ramp_div #(
    .COLOR_BITS (COLOR_BITS),
    .SPAN_W     (SPAN_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (div_req),
    .mag_i     (div_mag),
    .divisor_i (ld_major),
    .busy_o    (div_busy),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // step and load update
  always_comb begin
    logic            steep, dpos;
    logic [SPAN_W:0] esum;
    cur_x_d  = cur_x_q;
    cur_y_d  = cur_y_q;
    major_d  = major_q;
    minor_d  = minor_q;
    dec_d    = dec_q;
    steps_d  = steps_q;
    dir_d    = dir_q;
    val_d    = val_q;
    err_d    = err_q;
    active_d = active_q;
    steep    = dir_q[0];
    dpos     = (dec_q > 0);
    esum     = '0;
    if (load_fire) begin
      cur_x_d  = in_if.x0;
      cur_y_d  = in_if.y0;
      major_d  = ld_major;
      minor_d  = ld_minor;
      dec_d    = $signed(DEC_W'({ld_minor, 1'b0})) - $signed(DEC_W'(ld_major));
      steps_d  = ld_major;
      dir_d    = {dy_s[COORD_BITS], dx_s[COORD_BITS], ld_steep};
      val_d    = start_q;
      err_d    = '0;
      active_d = (ld_major != '0);
    end else if (produce) begin
      if (steep || dpos) begin
        cur_y_d = dir_q[2] ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
      end
      if (!steep || dpos) begin
        cur_x_d = dir_q[1] ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
      end
      if (dpos) begin
        dec_d = dec_q + $signed(DEC_W'({minor_q, 1'b0})) - $signed(DEC_W'({major_q, 1'b0}));
      end else begin
        dec_d = dec_q + $signed(DEC_W'({minor_q, 1'b0}));
      end
      for (int c = 0; c < NCH; c++) begin
        esum = {1'b0, err_q[c]} + {1'b0, div_rem[c]};
        if (esum >= {1'b0, major_q}) begin
          err_d[c] = SPAN_W'(esum - {1'b0, major_q});
          val_d[c] = val_q[c] + div_quot[c][COLOR_BITS-1:0] + 1'b1;
        end else begin
          err_d[c] = esum[SPAN_W-1:0];
          val_d[c] = val_q[c] + div_quot[c][COLOR_BITS-1:0];
        end
      end
      steps_d = steps_q - 1'b1;
      if (last_now) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      major_q  <= '0;
      minor_q  <= '0;
      dec_q    <= '0;
      steps_q  <= '0;
      dir_q    <= '0;
      val_q    <= '0;
      err_q    <= '0;
      active_q <= 1'b0;
    end else begin
      cur_x_q  <= cur_x_d;
      cur_y_q  <= cur_y_d;
      major_q  <= major_d;
      minor_q  <= minor_d;
      dec_q    <= dec_d;
      steps_q  <= steps_d;
      dir_q    <= dir_d;
      val_q    <= val_d;
      err_q    <= err_d;
      active_q <= active_d;
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= produce;
      end
    end else if (produce) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_fire) begin
      if (skid_valid_q) begin
        out_x_q    <= skid_x_q;
        out_y_q    <= skid_y_q;
        out_c_q    <= skid_c_q;
        out_last_q <= skid_last_q;
      end else if (produce) begin
        out_x_q    <= cur_x_q;
        out_y_q    <= cur_y_q;
        out_c_q    <= val_q;
        out_last_q <= last_now;
      end
    end else if (produce) begin
      skid_x_q    <= cur_x_q;
      skid_y_q    <= cur_y_q;
      skid_c_q    <= val_q;
      skid_last_q <= last_now;
    end
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.pixel_x    = out_x_q;
  assign out_if.pixel_y    = out_y_q;
  assign out_if.red        = out_c_q[0];
  assign out_if.green      = out_c_q[1];
  assign out_if.blue       = out_c_q[2];
  assign out_if.last_pixel = out_last_q;

  // checks
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds an item while the output register is empty");

  a_active_has_steps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (steps_q != '0))
    else $error("line active with no pixels left");

  a_idle_step_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !active_q && !out_valid_q) |=> !out_valid_q)
    else $error("item produced while no line was active");

  a_line_end_on_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !in_fire) |=> active_q)
    else $error("line ended without an accepted item");

  a_no_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |=> (div_busy && !in_if.ready))
    else $error("input open while the colour step is still being divided");

endmodule

`default_nettype wire
